FILE: hw/rtl/lpfc_pkg.sv
// Shared types and constants for the page-addressed LCD framebuffer controller.
// No dependencies; imported by every module of the block.
package lpfc_pkg;

    // Panel geometry and store size
    localparam int COLUMNS     = 128;
    localparam int ROWS        = 64;
    localparam int PAGES       = ROWS / 8;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = 13;

    // Command byte codes
    localparam logic [7:0] CMD_CONTRAST   = 8'h81;
    localparam logic [7:0] CMD_BOOSTER    = 8'hF8;
    localparam logic [2:0] CMD_START_HI   = 3'b010;
    localparam logic [3:0] CMD_PAGE_HI    = 4'hB;
    localparam logic [2:0] CMD_COLUMN_HI  = 3'b000;
    localparam logic [7:0] PRESEL_COL_MAX = 8'd2;

    // Request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_en;
        logic wr_step;
        logic rd_issue;
        logic rd_load;
    } lpfc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
    } lpfc_status_t;

endpackage

FILE: hw/rtl/lpfc_ctrl.sv
// Sequencer of the LCD framebuffer controller: clearing pass, handshakes, read wait.
// Depends on lpfc_pkg.
module lpfc_ctrl
    import lpfc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_req_type,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  lpfc_status_t status,
    output lpfc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.clear_en = (state_reg == ST_CLEAR);
        cmd.wr_step  = accept && (s_req_type == REQ_WRITE);
        cmd.rd_issue = accept && (s_req_type == REQ_READ);
        cmd.rd_load  = (state_reg == ST_READ);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (cmd.rd_issue) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (cmd.wr_step || cmd.rd_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: hw/rtl/lpfc_datapath.sv
// Datapath of the LCD framebuffer controller: address state, byte decode, frame store.
// Depends on lpfc_pkg.
module lpfc_datapath
    import lpfc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lpfc_cmd_t         cmd,
    output lpfc_status_t      status,
    input  logic [7:0]        byte_value,
    input  logic              data_line,
    input  logic [ADDR_W-1:0] read_address,
    output logic [7:0]        read_data,
    output logic              frame_updated,
    output logic [4:0]        start_line_out,
    output logic [3:0]        page_out,
    output logic [7:0]        column_out
);

    logic [7:0] frame_mem [STORE_DEPTH];
    logic [7:0] mem_q_reg;
    logic [7:0] rd_out_reg;

    logic [ADDR_W-1:0] clr_addr_reg;

    logic [7:0] column_reg, column_next;
    logic [3:0] page_reg, page_next;
    logic [4:0] start_reg, start_next;
    logic       psel_reg, psel_next;
    logic       dwr_reg, dwr_next;
    logic       pend_reg, pend_next;
    logic       upd_reg, upd_next;

    logic [IDX_W-1:0] store_idx;
    logic             store_en;

    assign status.clear_last = cmd.clear_en && (&clr_addr_reg);

    assign store_idx = IDX_W'(page_reg) * IDX_W'(COLUMNS) + IDX_W'(column_reg);

    // Byte decode: state after one written byte
    always_comb begin
        column_next = column_reg;
        page_next   = page_reg;
        start_next  = start_reg;
        psel_next   = psel_reg;
        dwr_next    = dwr_reg;
        pend_next   = pend_reg;
        store_en    = 1'b0;
        if (data_line) begin
            if (!psel_reg) begin
                if (byte_value[7:4] == CMD_PAGE_HI) begin
                    if (column_reg <= PRESEL_COL_MAX) begin
                        psel_next   = 1'b1;
                        page_next   = byte_value[3:0];
                        column_next = 8'd1;
                    end
                end else begin
                    column_next = column_reg + 8'd1;
                end
            end else begin
                dwr_next = 1'b1;
                store_en = (column_reg < 8'(COLUMNS)) && ({1'b0, page_reg} < 5'(PAGES))
                           && (store_idx < IDX_W'(STORE_DEPTH));
                column_next = column_reg + 8'd1;
            end
        end else begin
            if (dwr_reg) begin
                psel_next   = 1'b0;
                dwr_next    = 1'b0;
                column_next = 8'd0;
                page_next   = 4'd0;
            end
            if (pend_reg) begin
                pend_next = 1'b0;
            end else if (byte_value == CMD_CONTRAST || byte_value == CMD_BOOSTER) begin
                pend_next = 1'b1;
            end else if (byte_value[7:5] == CMD_START_HI) begin
                start_next = byte_value[4:0];
            end else if (byte_value[7:4] == CMD_PAGE_HI) begin
                psel_next = 1'b1;
                page_next = byte_value[3:0];
            end else if (byte_value[7:5] == CMD_COLUMN_HI) begin
                if (byte_value[4]) begin
                    column_next = {byte_value[3:0], column_next[3:0]};
                end else begin
                    column_next = {column_next[7:4], byte_value[3:0]};
                end
            end
        end
        upd_next = upd_reg || dwr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= '0;
            page_reg     <= '0;
            start_reg    <= '0;
            psel_reg     <= 1'b0;
            dwr_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            upd_reg      <= 1'b0;
            clr_addr_reg <= '0;
        end else begin
            if (cmd.clear_en) clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (cmd.wr_step) begin
                column_reg <= column_next;
                page_reg   <= page_next;
                start_reg  <= start_next;
                psel_reg   <= psel_next;
                dwr_reg    <= dwr_next;
                pend_reg   <= pend_next;
                upd_reg    <= upd_next;
            end
        end
    end

    // Frame store: clearing pass, then at most one write or one read per item
    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            frame_mem[clr_addr_reg] <= 8'd0;
        end else if (cmd.wr_step && store_en) begin
            frame_mem[store_idx[ADDR_W-1:0]] <= byte_value;
        end
        if (cmd.rd_issue) mem_q_reg <= frame_mem[read_address];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_step) begin
            rd_out_reg <= 8'd0;
        end else if (cmd.rd_load) begin
            rd_out_reg <= mem_q_reg;
        end
    end

    assign read_data      = rd_out_reg;
    assign frame_updated  = upd_reg;
    assign start_line_out = start_reg;
    assign page_out       = page_reg;
    assign column_out     = column_reg;

endmodule

FILE: hw/rtl/lcd_page_framebuffer_controller_top.sv
// Top level of the page-addressed monochrome LCD framebuffer controller.
// Depends on lpfc_pkg, lpfc_ctrl and lpfc_datapath.
//
// Each input item either writes one controller byte (req_type 0, routed to the
// pixel-data handler when data_line is 1, to the command handler otherwise) or
// reads one byte of the 1024-byte frame store (req_type 1). Every item gives one
// result item carrying the read byte (zero for writes) and the display state
// after the item: sticky frame-updated flag, start line, page and column. A
// write result is registered directly; a read passes the registered read
// port of the frame store and then the result register. One item is in
// flight at a time; the next is taken in the same cycle that the previous
// result is taken. After reset a clearing pass zeroes all 1024 bytes of the
// store, one byte per cycle, and s_ready stays low until it is done.
module lcd_page_framebuffer_controller_top
    import lpfc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [7:0]        s_byte_value,
    input  logic              s_data_line,
    input  logic [ADDR_W-1:0] s_read_address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_read_data,
    output logic              m_frame_updated,
    output logic [4:0]        m_start_line_out,
    output logic [3:0]        m_page_out,
    output logic [7:0]        m_column_out
);

    lpfc_cmd_t    cmd;
    lpfc_status_t status;

    // Sequencer: hold s_ready low during the clearing pass and the read wait
    lpfc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: address state and frame store; state registers double as
    // result payload since no new item advances them while a result waits
    lpfc_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .byte_value     (s_byte_value),
        .data_line      (s_data_line),
        .read_address   (s_read_address),
        .read_data      (m_read_data),
        .frame_updated  (m_frame_updated),
        .start_line_out (m_start_line_out),
        .page_out       (m_page_out),
        .column_out     (m_column_out)
    );

endmodule

FILE: hw/rtl/lpfc_checker.sv
// Port-level checker for the LCD framebuffer controller, bound to the top level.
// Depends on lpfc_pkg and lcd_page_framebuffer_controller_top.
module lpfc_checker
    import lpfc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_req_type,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_frame_updated
);

    logic last_type_reg;
    logic seen_upd_reg;

    // Track the type of the item in flight and whether the flag was ever shown
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_type_reg <= REQ_WRITE;
            seen_upd_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) last_type_reg <= s_req_type;
            if (m_valid && m_ready && m_frame_updated) seen_upd_reg <= 1'b1;
        end
    end

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped before it was taken");

    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_upd_reg |-> m_frame_updated)
        else $error("frame updated flag cleared after being set");

    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (last_type_reg == REQ_WRITE) |-> m_read_data == 8'd0)
        else $error("write item returned nonzero read data");

    a_read_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_READ) |=> !s_ready && !m_valid)
        else $error("read item did not wait for the store read");

endmodule

bind lcd_page_framebuffer_controller_top lpfc_checker u_lpfc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_req_type      (s_req_type),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_read_data     (m_read_data),
    .m_frame_updated (m_frame_updated)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for lcd_page_framebuffer_controller_top.
// Depends on lpfc_pkg for geometry, command codes and request types.
module testbench;
    import lpfc_pkg::*;

    localparam logic LINE_CMD   = 1'b0;
    localparam logic LINE_DATA  = 1'b1;
    localparam logic COL_HI_SEL = 1'b1;
    localparam logic COL_LO_SEL = 1'b0;
    // Command byte that decodes to nothing
    localparam logic [7:0] CMD_UNUSED = 8'hE3;

    // One result item as the block presents it
    typedef struct packed {
        logic [7:0] read_data;
        logic       frame_updated;
        logic [4:0] start_line;
        logic [3:0] page;
        logic [7:0] column;
    } lcd_result_t;

    // Display-state tracker and queue of predicted result items
    class lcd_scoreboard;
        logic [7:0]  frame_mem [STORE_DEPTH];
        logic [7:0]  column;
        logic [3:0]  page;
        logic [4:0]  start_line;
        bit          page_sel;
        bit          data_seen;
        bit          skip_next_cmd;
        bit          updated;
        lcd_result_t predicted_q[$];
        int          errors;

        function new();
            foreach (frame_mem[i]) frame_mem[i] = 8'h00;
            column        = 8'h00;
            page          = 4'h0;
            start_line    = 5'h00;
            page_sel      = 1'b0;
            data_seen     = 1'b0;
            skip_next_cmd = 1'b0;
            updated       = 1'b0;
            errors        = 0;
        endfunction

        function void pixel_byte(logic [7:0] v);
            int idx;
            if (!page_sel) begin
                if (v[7:4] == CMD_PAGE_HI) begin
                    // too far along the column to be a page select: drop it
                    if (column > PRESEL_COL_MAX) return;
                    page_sel = 1'b1;
                    page     = v[3:0];
                    column   = 8'h00;
                end
                column = column + 8'd1;
                return;
            end
            data_seen = 1'b1;
            if (column < COLUMNS && page < PAGES) begin
                idx = int'(page) * COLUMNS + int'(column);
                if (idx < STORE_DEPTH) frame_mem[idx] = v;
            end
            column = column + 8'd1;
        endfunction

        function void command_byte(logic [7:0] v);
            if (data_seen) begin
                page_sel  = 1'b0;
                data_seen = 1'b0;
                column    = 8'h00;
                page      = 4'h0;
            end
            if (skip_next_cmd) begin
                skip_next_cmd = 1'b0;
                return;
            end
            if (v == CMD_CONTRAST || v == CMD_BOOSTER) begin
                skip_next_cmd = 1'b1;
            end else if (v[7:5] == CMD_START_HI) begin
                start_line = v[4:0];
            end else if (v[7:4] == CMD_PAGE_HI) begin
                page_sel = 1'b1;
                page     = v[3:0];
            end else if (v[7:5] == CMD_COLUMN_HI) begin
                if (v[4] == COL_HI_SEL) column = {v[3:0], column[3:0]};
                else                    column = {column[7:4], v[3:0]};
            end
        endfunction

        function void note_item(logic rt, logic [7:0] bv, logic dl, logic [ADDR_W-1:0] ra);
            lcd_result_t r;
            r.read_data = 8'h00;
            if (rt == REQ_READ) begin
                r.read_data = frame_mem[ra];
            end else begin
                if (dl == LINE_DATA) pixel_byte(bv);
                else                 command_byte(bv);
                if (data_seen) updated = 1'b1;
            end
            r.frame_updated = updated;
            r.start_line    = start_line;
            r.page          = page;
            r.column        = column;
            predicted_q.push_back(r);
        endfunction

        function void check_field(string field, logic [7:0] exp, logic [7:0] act);
            if (act !== exp) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp, act);
            end
        endfunction

        function void check_result(lcd_result_t got);
            lcd_result_t exp;
            if (predicted_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual %0h",
                         $time, got);
                return;
            end
            exp = predicted_q.pop_front();
            check_field("read_data",      exp.read_data,            got.read_data);
            check_field("frame_updated",  {7'd0, exp.frame_updated}, {7'd0, got.frame_updated});
            check_field("start_line_out", {3'd0, exp.start_line},   {3'd0, got.start_line});
            check_field("page_out",       {4'd0, exp.page},         {4'd0, got.page});
            check_field("column_out",     exp.column,               got.column);
        endfunction

        function int outstanding();
            return predicted_q.size();
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_req_type;
    logic [7:0]        s_byte_value;
    logic              s_data_line;
    logic [ADDR_W-1:0] s_read_address;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_read_data;
    logic              m_frame_updated;
    logic [4:0]        m_start_line_out;
    logic [3:0]        m_page_out;
    logic [7:0]        m_column_out;

    lcd_scoreboard sb;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            items_sent;

    lcd_page_framebuffer_controller_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_byte_value     (s_byte_value),
        .s_data_line      (s_data_line),
        .s_read_address   (s_read_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_data      (m_read_data),
        .m_frame_updated  (m_frame_updated),
        .m_start_line_out (m_start_line_out),
        .m_page_out       (m_page_out),
        .m_column_out     (m_column_out)
    );

    always #4 aclk = ~aclk;

    // Stall the result channel at the current receiver idle rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watch both handshakes; note the input first so a same-edge result
    // always finds its prediction already queued
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready)
                sb.note_item(s_req_type, s_byte_value, s_data_line, s_read_address);
            if (m_valid && m_ready)
                sb.check_result({m_read_data, m_frame_updated, m_start_line_out,
                                 m_page_out, m_column_out});
        end
    end

    // Present one item, idling first at the sender rate; return at the
    // edge where it is taken
    task automatic drive_item(input logic rt, input logic [7:0] bv, input logic dl,
                              input logic [ADDR_W-1:0] ra);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= rt;
        s_byte_value   <= bv;
        s_data_line    <= dl;
        s_read_address <= ra;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Fields that the block ignores get random values so their bits toggle
    task automatic write_cmd(input logic [7:0] v);
        drive_item(REQ_WRITE, v, LINE_CMD, ADDR_W'($urandom));
    endtask

    task automatic write_data(input logic [7:0] v);
        drive_item(REQ_WRITE, v, LINE_DATA, ADDR_W'($urandom));
    endtask

    task automatic read_byte(input logic [ADDR_W-1:0] a);
        drive_item(REQ_READ, 8'($urandom), 1'($urandom), a);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic run_directed;
        read_byte(ADDR_W'(0));
        read_byte(ADDR_W'(STORE_DEPTH - 1));
        // data before any page select: advance, then select page 3
        write_data(8'h55);
        write_data({CMD_PAGE_HI, 4'h3});
        write_data(8'hFF);
        write_data(8'h00);
        read_byte(ADDR_W'(3 * COLUMNS + 1));
        // first command after data clears page and column
        write_cmd({CMD_START_HI, 5'h1F});
        // two-byte commands swallow whatever follows
        write_cmd(CMD_CONTRAST);
        write_cmd({CMD_START_HI, 5'h00});
        write_cmd(CMD_BOOSTER);
        write_cmd(CMD_CONTRAST);
        write_cmd({CMD_PAGE_HI, 4'h7});
        write_cmd({CMD_COLUMN_HI, COL_HI_SEL, 4'hF});
        write_cmd({CMD_COLUMN_HI, COL_LO_SEL, 4'hF});
        // column past the panel edge: not stored, wraps to zero
        write_data(8'hA5);
        write_data(8'h5A);
        read_byte(ADDR_W'(7 * COLUMNS));
        // page past the panel: not stored
        write_cmd({CMD_PAGE_HI, 4'hF});
        write_data(8'h3C);
        write_cmd({CMD_COLUMN_HI, COL_HI_SEL, 4'h0});
        write_cmd({CMD_COLUMN_HI, COL_LO_SEL, 4'h3});
        // page-select data byte with column beyond two changes nothing
        write_data({CMD_PAGE_HI, 4'h5});
        write_cmd(CMD_UNUSED);
        drive_item(REQ_READ, 8'hFF, LINE_DATA, {ADDR_W{1'b1}});
    endtask

    task automatic run_random(input int count);
        int          target;
        int          kind;
        int          n;
        logic [3:0]  pg;
        logic [3:0]  col_hi;
        target = items_sent + count;
        while (items_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                // page select, optional column set, pixel burst, read back
                pg = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(PAGES - 1));
                write_cmd({CMD_PAGE_HI, pg});
                if ($urandom_range(1)) begin
                    col_hi = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(7));
                    write_cmd({CMD_COLUMN_HI, COL_HI_SEL, col_hi});
                    write_cmd({CMD_COLUMN_HI, COL_LO_SEL, 4'($urandom)});
                end
                n = $urandom_range(1, 12);
                repeat (n) write_data(8'($urandom));
                n = $urandom_range(0, 3);
                repeat (n) begin
                    if ($urandom_range(1))
                        read_byte(ADDR_W'(int'(pg[2:0]) * COLUMNS + $urandom_range(COLUMNS - 1)));
                    else
                        read_byte(ADDR_W'($urandom));
                end
            end else if (kind < 60) begin
                // clear page state, then select a page through the data line
                write_cmd({CMD_START_HI, 5'($urandom)});
                write_cmd({CMD_COLUMN_HI, COL_HI_SEL, 4'h0});
                write_cmd({CMD_COLUMN_HI, COL_LO_SEL, 4'($urandom_range(3))});
                n = $urandom_range(0, 2);
                repeat (n) write_data(8'($urandom));
                write_data({CMD_PAGE_HI, 4'($urandom)});
                n = $urandom_range(1, 6);
                repeat (n) write_data(8'($urandom));
            end else if (kind < 70) begin
                write_cmd($urandom_range(1) ? CMD_CONTRAST : CMD_BOOSTER);
                write_cmd(8'($urandom));
            end else if (kind < 80) begin
                n = $urandom_range(1, 4);
                repeat (n) read_byte(ADDR_W'($urandom));
            end else begin
                drive_item(1'($urandom), 8'($urandom), 1'($urandom), ADDR_W'($urandom));
            end
        end
    endtask

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        items_sent     = 0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_req_type     <= REQ_WRITE;
        s_byte_value   <= 8'h00;
        s_data_line    <= LINE_CMD;
        s_read_address <= '0;
        m_ready        <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase one: light sender idling, heavy receiver stalls
        send_idle_pct = 15;
        recv_idle_pct = 62;
        run_directed();
        run_random(250);
        drain();

        // Phase two: the other way round
        send_idle_pct = 62;
        recv_idle_pct = 15;
        run_random(250);
        drain();

        // Phase three: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(250);
        drain();

        // Let any stray result surface before the verdict
        repeat (16) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog well past the slowest legal run, clearing pass included
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: lcd_page_framebuffer_controller_top.f
hw/rtl/lpfc_pkg.sv
hw/rtl/lpfc_ctrl.sv
hw/rtl/lpfc_datapath.sv
hw/rtl/lcd_page_framebuffer_controller_top.sv
hw/rtl/lpfc_checker.sv
bench/testbench.sv
